[hdl/escal_pkg.sv]
// shared types and constants for the encoder sector trimmed-mean calibration block
// no dependencies; the interfaces, the top level and the checker refer to this package by scoped name
package escal_pkg;

  // defaults for the top-level parameters
  localparam int SECTORS_DEF       = 32;
  localparam int REVS_DEF          = 16;
  localparam int INTERVAL_BITS_DEF = 24;

  // fixed field widths of the channels
  localparam int SECTOR_W   = 5;
  localparam int INTERVAL_W = 24;
  localparam int CORR_W     = 20;

  // number of table entries that can be emitted
  localparam int MAX_EMIT = 32;

  // fixed-point scaling: means and corrections carry 8 fractional bits
  localparam int FRAC_BITS = 8;
  localparam int PCT_SCALE = 100;

  typedef logic [SECTOR_W-1:0]   sector_t;
  typedef logic [INTERVAL_W-1:0] interval_t;
  typedef logic [CORR_W-1:0]     corr_t;

  typedef enum logic [3:0] {
    ST_IDLE,   // taking items
    ST_UPD,    // read-modify-write of one sector accumulator
    ST_MRD,    // mean pass: read accumulator
    ST_MDAT,   // mean pass: trim and start division
    ST_MDIV,   // mean pass: wait for divider
    ST_MWR,    // mean pass: store mean, add to total
    ST_CRD,    // correction pass: read mean
    ST_CMUL,   // correction pass: scale mean
    ST_CST,    // correction pass: start division
    ST_CDIV,   // correction pass: wait for divider
    ST_COUT    // correction pass: hand entry to output register
  } state_t;

endpackage

[hdl/escal_if.sv]
// channel interfaces: sample input, correction output and configuration write
// depends on escal_pkg for the field types
interface escal_sample_if;
  logic                  valid;
  logic                  ready;
  escal_pkg::sector_t    sector;
  escal_pkg::interval_t  interval_us;
  logic                  finish;

  modport source (output valid, output sector, output interval_us, output finish,
                  input ready);
  modport sink   (input valid, input sector, input interval_us, input finish,
                  output ready);
endinterface

interface escal_result_if;
  logic               valid;
  logic               ready;
  escal_pkg::sector_t out_sector;
  escal_pkg::corr_t   correction;
  logic               direction_column;
  logic               last_entry;

  modport source (output valid, output out_sector, output correction,
                  output direction_column, output last_entry, input ready);
  modport sink   (input valid, input out_sector, input correction,
                  input direction_column, input last_entry, output ready);
endinterface

interface escal_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/escal_ram.sv]
// generic single-write, single-read memory with registered read data
// no dependencies
module escal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/escal_div.sv]
// shared restoring divider, one quotient bit per cycle
// no dependencies; used for both the sector means and the corrections
module escal_div #(
  parameter int NW = 40,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);

  localparam int SBW = $clog2(NW);

  logic          busy;
  logic [SBW-1:0] steps;
  logic [DW-1:0] rem;
  logic [DW-1:0] den_q;
  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;

  // quotient bits shift in from the bottom while numerator bits leave the top
  assign rem_sh = {rem, quot[NW-1]};
  assign diff   = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && steps == SBW'(NW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quot  <= num;
      den_q <= den;
      steps <= '0;
    end else if (busy) begin
      steps <= steps + 1'b1;
      if (!diff[DW]) begin
        rem  <= diff[DW-1:0];
        quot <= {quot[NW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[DW-1:0];
        quot <= {quot[NW-2:0], 1'b0};
      end
    end
  end

endmodule

[hdl/encoder_sector_trimmed_mean_calibration_core.sv]
// top level: sector accumulators, sequencer for the mean and correction passes
// depends on escal_pkg, the channel interfaces, escal_ram and escal_div
//
//  channel  dir  payload                                              transfer
//  sample   in   sector, interval_us, finish                          valid & ready
//  result   out  out_sector, correction, direction_column, last_entry valid & ready
//  cfg      in   data (direction_inverted)                            valid & ready
//
// a sample reads its accumulator, then writes it back; sample.ready is high only when idle
// a finish runs the mean pass over all SECTORS, then the correction pass over min(SECTORS, 32)
// entries, on the shared one-bit-per-cycle divider with a numerator width of 52 at the defaults
// result entries sit in an output register; a stalled sink holds the correction pass
// rst is synchronous; accumulators read as cleared through per-sector valid bits, no sweep
module encoder_sector_trimmed_mean_calibration_core #(
  parameter int SECTORS       = escal_pkg::SECTORS_DEF,
  parameter int REVS          = escal_pkg::REVS_DEF,
  parameter int INTERVAL_BITS = escal_pkg::INTERVAL_BITS_DEF
) (
  input logic             clk,
  input logic             rst,
  escal_sample_if.sink    sample,
  escal_result_if.source  result,
  escal_cfg_if.sink       cfg
);

  localparam int VB    = (INTERVAL_BITS < escal_pkg::INTERVAL_W) ?
                         INTERVAL_BITS : escal_pkg::INTERVAL_W;
  localparam int CW    = $clog2(REVS + 1);
  localparam int SW    = VB + CW;
  localparam int MW    = VB + escal_pkg::FRAC_BITS;
  localparam int AW    = $clog2(SECTORS);
  localparam int TW    = MW + $clog2(SECTORS);
  localparam int KMUL  = escal_pkg::PCT_SCALE * (1 << escal_pkg::FRAC_BITS) * SECTORS;
  localparam int KW    = $clog2(KMUL + 1);
  localparam int DNW   = MW + KW;
  localparam int DDW   = TW;
  localparam int ACCW  = SW + 2 * VB + CW;
  localparam int NEMIT = (SECTORS < escal_pkg::MAX_EMIT) ? SECTORS : escal_pkg::MAX_EMIT;
  localparam int CORR_W = escal_pkg::CORR_W;

  // accumulator word layout: {sum, min, max, count}
  localparam int CNT_LO = 0;
  localparam int MAX_LO = CW;
  localparam int MIN_LO = CW + VB;
  localparam int SUM_LO = CW + 2 * VB;

  escal_pkg::state_t state, state_next;

  logic [AW-1:0]      idx;
  logic [AW-1:0]      s_reg;
  logic [VB-1:0]      v_reg;
  logic [SECTORS-1:0] acc_valid;
  logic               dir;
  logic [TW-1:0]      total;
  logic [MW-1:0]      mean_reg;
  logic [DNW-1:0]     prod_reg;
  escal_pkg::corr_t   corr_reg;

  logic               out_valid;
  escal_pkg::sector_t out_sector_q;
  escal_pkg::corr_t   corr_q;
  logic               dir_q;
  logic               last_q;

  // memory ports
  logic [AW-1:0]   acc_raddr;
  logic [ACCW-1:0] acc_rdata;
  logic            acc_we;
  logic [ACCW-1:0] acc_wdata;
  logic            mean_we;
  logic [MW-1:0]   mean_rdata;

  // divider
  logic           div_start;
  logic [DNW-1:0] div_num;
  logic [DDW-1:0] div_den;
  logic           div_done;
  logic [DNW-1:0] div_quot;

  // decoded accumulator entry, cleared entries read as reset values
  logic          entry_valid;
  logic [SW-1:0] old_sum;
  logic [VB-1:0] old_min;
  logic [VB-1:0] old_max;
  logic [CW-1:0] old_cnt;
  logic [SW-1:0] trim_sum;
  logic [CW-1:0] trim_cnt;
  logic          upd_take;
  logic          sample_xfer;
  logic          sample_ok;
  logic          last_idx_mean;
  logic          last_idx_emit;
  logic          out_load;
  escal_pkg::corr_t corr_sat;

  escal_ram #(.WIDTH(ACCW), .DEPTH(SECTORS)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (s_reg),
    .wdata (acc_wdata),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  escal_ram #(.WIDTH(MW), .DEPTH(SECTORS)) u_mean_ram (
    .clk   (clk),
    .we    (mean_we),
    .waddr (idx),
    .wdata (mean_reg),
    .raddr (idx),
    .rdata (mean_rdata)
  );

  escal_div #(.NW(DNW), .DW(DDW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign sample_xfer   = sample.valid && sample.ready;
  assign sample_ok     = (sample.interval_us[VB-1:0] != '0) &&
                         (32'(sample.sector) < 32'(SECTORS));
  assign last_idx_mean = (idx == AW'(SECTORS - 1));
  assign last_idx_emit = (idx == AW'(NEMIT - 1));

  // in the update state the address is the registered sample sector
  assign entry_valid = (state == escal_pkg::ST_UPD) ? acc_valid[s_reg] : acc_valid[idx];
  assign old_sum = entry_valid ? acc_rdata[SUM_LO +: SW] : '0;
  assign old_min = entry_valid ? acc_rdata[MIN_LO +: VB] : '1;
  assign old_max = entry_valid ? acc_rdata[MAX_LO +: VB] : '0;
  assign old_cnt = entry_valid ? acc_rdata[CNT_LO +: CW] : '0;

  assign upd_take = (old_cnt < CW'(REVS));

  // drop min and max once more than two samples are in
  always_comb begin
    if (old_cnt > CW'(2)) begin
      trim_sum = old_sum - SW'(old_min) - SW'(old_max);
      trim_cnt = old_cnt - CW'(2);
    end else begin
      trim_sum = old_sum;
      trim_cnt = old_cnt;
    end
  end

  assign corr_sat = (|div_quot[DNW-1:CORR_W]) ? '1 : div_quot[CORR_W-1:0];
  assign out_load = (state == escal_pkg::ST_COUT) && !out_valid;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      escal_pkg::ST_IDLE: begin
        if (sample.valid) begin
          if (sample.finish) begin
            state_next = escal_pkg::ST_MRD;
          end else if (sample_ok) begin
            state_next = escal_pkg::ST_UPD;
          end
        end
      end
      escal_pkg::ST_UPD:  state_next = escal_pkg::ST_IDLE;
      escal_pkg::ST_MRD:  state_next = escal_pkg::ST_MDAT;
      escal_pkg::ST_MDAT: begin
        state_next = (trim_cnt == '0) ? escal_pkg::ST_MWR : escal_pkg::ST_MDIV;
      end
      escal_pkg::ST_MDIV: begin
        if (div_done) begin
          state_next = escal_pkg::ST_MWR;
        end
      end
      escal_pkg::ST_MWR: begin
        state_next = last_idx_mean ? escal_pkg::ST_CRD : escal_pkg::ST_MRD;
      end
      escal_pkg::ST_CRD:  state_next = escal_pkg::ST_CMUL;
      escal_pkg::ST_CMUL: state_next = escal_pkg::ST_CST;
      escal_pkg::ST_CST: begin
        state_next = (total == '0) ? escal_pkg::ST_COUT : escal_pkg::ST_CDIV;
      end
      escal_pkg::ST_CDIV: begin
        if (div_done) begin
          state_next = escal_pkg::ST_COUT;
        end
      end
      escal_pkg::ST_COUT: begin
        if (!out_valid) begin
          state_next = last_idx_emit ? escal_pkg::ST_IDLE : escal_pkg::ST_CRD;
        end
      end
      default: state_next = escal_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    sample.ready = (state == escal_pkg::ST_IDLE);
    cfg.ready    = 1'b1;
    acc_raddr    = (state == escal_pkg::ST_IDLE) ? AW'(sample.sector) : idx;
    acc_we       = 1'b0;
    acc_wdata    = '0;
    mean_we      = 1'b0;
    div_start    = 1'b0;
    div_num      = prod_reg;
    div_den      = total;
    unique case (state)
      escal_pkg::ST_UPD: begin
        acc_we    = upd_take;
        acc_wdata = {old_sum + SW'(v_reg),
                     (v_reg < old_min) ? v_reg : old_min,
                     (v_reg > old_max) ? v_reg : old_max,
                     old_cnt + 1'b1};
      end
      escal_pkg::ST_MDAT: begin
        div_start = (trim_cnt != '0);
        div_num   = DNW'({trim_sum, {escal_pkg::FRAC_BITS{1'b0}}});
        div_den   = DDW'(trim_cnt);
      end
      escal_pkg::ST_MWR: begin
        mean_we = 1'b1;
      end
      escal_pkg::ST_CST: begin
        div_start = (total != '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= escal_pkg::ST_IDLE;
      out_valid <= 1'b0;
      acc_valid <= '0;
      dir       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        dir <= cfg.data;
      end
      if (acc_we) begin
        acc_valid[s_reg] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
        // table done: accumulators go back to their cleared values
        if (last_idx_emit) begin
          acc_valid <= '0;
        end
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (sample_xfer) begin
      s_reg <= AW'(sample.sector);
      v_reg <= sample.interval_us[VB-1:0];
      if (sample.finish) begin
        idx   <= '0;
        total <= '0;
      end
    end
    unique case (state)
      escal_pkg::ST_MDAT: begin
        mean_reg <= '0;
      end
      escal_pkg::ST_MDIV: begin
        if (div_done) begin
          mean_reg <= div_quot[MW-1:0];
        end
      end
      escal_pkg::ST_MWR: begin
        total <= total + TW'(mean_reg);
        idx   <= last_idx_mean ? '0 : idx + 1'b1;
      end
      escal_pkg::ST_CMUL: begin
        prod_reg <= DNW'(mean_rdata) * DNW'(KMUL);
      end
      escal_pkg::ST_CST: begin
        corr_reg <= '0;
      end
      escal_pkg::ST_CDIV: begin
        if (div_done) begin
          corr_reg <= corr_sat;
        end
      end
      escal_pkg::ST_COUT: begin
        if (!out_valid) begin
          out_sector_q <= escal_pkg::sector_t'(idx);
          corr_q       <= corr_reg;
          dir_q        <= dir;
          last_q       <= last_idx_emit;
          idx          <= idx + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign result.valid            = out_valid;
  assign result.out_sector       = out_sector_q;
  assign result.correction       = corr_q;
  assign result.direction_column = dir_q;
  assign result.last_entry       = last_q;

endmodule

[hdl/escal_chk.sv]
// port-level checker for the calibration core, bound to the top level
// depends on escal_pkg and the top level's channel interfaces
module escal_chk #(
  parameter int NEMIT = escal_pkg::MAX_EMIT
) (
  input logic               clk,
  input logic               rst,
  input logic               s_valid,
  input logic               s_ready,
  input logic               s_finish,
  input logic               r_valid,
  input logic               r_ready,
  input escal_pkg::sector_t r_sector,
  input escal_pkg::corr_t   r_correction,
  input logic               r_last
);

  // a finish always starts the computation, so input is closed the next cycle
  a_finish_closes: assert property (@(posedge clk) disable iff (rst)
    s_valid && s_ready && s_finish |=> !s_ready)
    else $error("input still open after finish transfer");

  // entries before the last one only show while the table is being computed
  a_table_busy: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_last |-> !s_ready)
    else $error("inner table entry shown while idle");

  // the last entry carries the highest emitted sector
  a_last_sector: assert property (@(posedge clk) disable iff (rst)
    r_valid && r_last |-> r_sector == escal_pkg::sector_t'(NEMIT - 1))
    else $error("last entry on wrong sector");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |=> r_valid && $stable(r_correction) && $stable(r_sector))
    else $error("stalled result changed");

endmodule

bind encoder_sector_trimmed_mean_calibration_core escal_chk #(
  .NEMIT((SECTORS < escal_pkg::MAX_EMIT) ? SECTORS : escal_pkg::MAX_EMIT)
) u_escal_chk (
  .clk          (clk),
  .rst          (rst),
  .s_valid      (sample.valid),
  .s_ready      (sample.ready),
  .s_finish     (sample.finish),
  .r_valid      (result.valid),
  .r_ready      (result.ready),
  .r_sector     (result.out_sector),
  .r_correction (result.correction),
  .r_last       (result.last_entry)
);
